### src/oofa_pkg.sv
// Shared constants, result codes and controller/datapath interface types
// for the oldest-first memory bank arbiter. No dependencies.
package oofa_pkg;

    localparam int NPROC   = 64;
    localparam int NMOD    = 256;
    localparam int PROC_W  = 6;
    localparam int MOD_W   = 8;
    localparam int CNT_W   = 7;
    localparam int PREG_W  = 7;
    localparam int MREG_W  = 9;
    localparam int TOT_W   = 32;
    localparam int KIND_W  = 2;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 88;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GRANT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam logic REG_PROCS = 1'b0;
    localparam logic REG_MODS  = 1'b1;

    typedef struct packed {
        logic req_eval;
        logic tick_start;
        logic age_rd;
        logic pm_rd;
        logic decide;
        logic tick_end;
        logic grant_rd;
        logic grant_show;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic any_grant;
        logic out_last;
    } sts_t;

endpackage

### src/oofa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module oofa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/oofa_ctrl.sv
// Sequencer for the arbiter: request handling, the tick walk over the age
// queue and the grant readout. Uses oofa_pkg.
module oofa_ctrl
    import oofa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  logic s_tuser,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_PM   = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;
    localparam logic [2:0] S_GRD  = 3'd5;
    localparam logic [2:0] S_GSH  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == FUNC_TICK)
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_RD;
                    end
                    else
                    begin
                        cmd.req_eval = 1'b1;
                        state_next   = S_OUT;
                    end
                end
            end
            S_RD:
            begin
                if (sts.more)
                begin
                    cmd.age_rd = 1'b1;
                    state_next = S_PM;
                end
                else
                begin
                    state_next = S_END;
                end
            end
            S_PM:
            begin
                cmd.pm_rd  = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = S_RD;
            end
            S_END:
            begin
                cmd.tick_end = 1'b1;
                state_next   = sts.any_grant ? S_GRD : S_OUT;
            end
            S_GRD:
            begin
                cmd.grant_rd = 1'b1;
                state_next   = S_GSH;
            end
            S_GSH:
            begin
                cmd.grant_show = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = sts.out_last ? S_IDLE : S_GRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/oofa_dp.sv
// Datapath: pending table, age queue, grant list, busy flags, totals and
// the result register. Uses oofa_pkg and oofa_ram.
module oofa_dp
    import oofa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [MREG_W-1:0]  cfg_data,
    input  logic [PROC_W-1:0]  in_proc,
    input  logic [MOD_W-1:0]   in_mod,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic [KIND_W-1:0]  out_kind,
    output logic [PROC_W-1:0]  out_proc,
    output logic [MOD_W-1:0]   out_mod,
    output logic [CNT_W-1:0]   out_waits,
    output logic [TOT_W-1:0]   out_wait_total,
    output logic [TOT_W-1:0]   out_req_total,
    output logic               out_last
);

    logic [PREG_W-1:0] procs_reg;
    logic [MREG_W-1:0] mods_reg;
    logic [NPROC-1:0]  pend_valid_reg;
    logic [NMOD-1:0]   busy_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  keep_reg;
    logic [CNT_W-1:0]  gcnt_reg;
    logic [CNT_W-1:0]  waits_reg;
    logic [CNT_W-1:0]  emit_idx_reg;
    logic [PROC_W-1:0] cur_p_reg;
    logic [TOT_W-1:0]  wait_tot_reg;
    logic [TOT_W-1:0]  req_tot_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [PROC_W-1:0] out_proc_reg;
    logic [MOD_W-1:0]  out_mod_reg;
    logic [CNT_W-1:0]  out_waits_reg;
    logic              out_last_reg;

    logic [PROC_W-1:0]       age_rdata;
    logic [MOD_W-1:0]        pm_rdata;
    logic [PROC_W+MOD_W-1:0] gr_rdata;
    logic                    req_ok;
    logic                    grant_now;
    logic                    age_we;
    logic [PROC_W-1:0]       age_waddr;
    logic [PROC_W-1:0]       age_wdata;
    logic [TOT_W:0]          wait_sum;

    assign req_ok = ({1'b0, in_proc} < procs_reg) && ({1'b0, in_mod} < mods_reg)
                    && !pend_valid_reg[in_proc];
    assign grant_now = !busy_reg[pm_rdata];
    assign wait_sum  = {1'b0, wait_tot_reg} + {{(TOT_W+1-CNT_W){1'b0}}, waits_reg};

    // Requests append at the tail; the walk rewrites blocked entries at keep.
    assign age_we    = (cmd.req_eval && req_ok) || (cmd.decide && !grant_now);
    assign age_waddr = cmd.req_eval ? count_reg[PROC_W-1:0] : keep_reg[PROC_W-1:0];
    assign age_wdata = cmd.req_eval ? in_proc : cur_p_reg;

    oofa_ram #(.WIDTH(PROC_W), .DEPTH(NPROC)) u_age (
        .clk     (clk),
        .wr_en   (age_we),
        .wr_addr (age_waddr),
        .wr_data (age_wdata),
        .rd_en   (cmd.age_rd),
        .rd_addr (rd_idx_reg[PROC_W-1:0]),
        .rd_data (age_rdata)
    );

    oofa_ram #(.WIDTH(MOD_W), .DEPTH(NPROC)) u_pmod (
        .clk     (clk),
        .wr_en   (cmd.req_eval && req_ok),
        .wr_addr (in_proc),
        .wr_data (in_mod),
        .rd_en   (cmd.pm_rd),
        .rd_addr (age_rdata),
        .rd_data (pm_rdata)
    );

    oofa_ram #(.WIDTH(PROC_W+MOD_W), .DEPTH(NPROC)) u_grant (
        .clk     (clk),
        .wr_en   (cmd.decide && grant_now),
        .wr_addr (gcnt_reg[PROC_W-1:0]),
        .wr_data ({pm_rdata, cur_p_reg}),
        .rd_en   (cmd.grant_rd),
        .rd_addr (emit_idx_reg[PROC_W-1:0]),
        .rd_data (gr_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            procs_reg      <= PREG_W'(NPROC);
            mods_reg       <= MREG_W'(NMOD);
            pend_valid_reg <= '0;
            busy_reg       <= '0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            keep_reg       <= '0;
            gcnt_reg       <= '0;
            waits_reg      <= '0;
            emit_idx_reg   <= '0;
            wait_tot_reg   <= '0;
            req_tot_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == REG_PROCS)
                begin
                    procs_reg <= cfg_data[PREG_W-1:0];
                end
                else
                begin
                    mods_reg <= cfg_data;
                end
            end
            if (cmd.req_eval)
            begin
                out_last_reg <= 1'b1;
                if (req_ok)
                begin
                    pend_valid_reg[in_proc] <= 1'b1;
                    count_reg               <= count_reg + 1'b1;
                    if (req_tot_reg != '1)
                    begin
                        req_tot_reg <= req_tot_reg + 1'b1;
                    end
                end
            end
            if (cmd.tick_start)
            begin
                busy_reg   <= '0;
                rd_idx_reg <= '0;
                keep_reg   <= '0;
                gcnt_reg   <= '0;
                waits_reg  <= '0;
            end
            if (cmd.decide)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
                if (grant_now)
                begin
                    busy_reg[pm_rdata]        <= 1'b1;
                    pend_valid_reg[cur_p_reg] <= 1'b0;
                    gcnt_reg                  <= gcnt_reg + 1'b1;
                end
                else
                begin
                    keep_reg  <= keep_reg + 1'b1;
                    waits_reg <= waits_reg + 1'b1;
                end
            end
            if (cmd.tick_end)
            begin
                count_reg    <= keep_reg;
                emit_idx_reg <= '0;
                wait_tot_reg <= wait_sum[TOT_W] ? '1 : wait_sum[TOT_W-1:0];
                out_last_reg <= 1'b1;
            end
            if (cmd.grant_show)
            begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
                out_last_reg <= (emit_idx_reg + 1'b1) == gcnt_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pm_rd)
        begin
            cur_p_reg <= age_rdata;
        end
        if (cmd.req_eval)
        begin
            out_kind_reg  <= req_ok ? KIND_ACCEPT : KIND_REJECT;
            out_proc_reg  <= in_proc;
            out_mod_reg   <= in_mod;
            out_waits_reg <= '0;
        end
        if (cmd.tick_end)
        begin
            // no grant: this result stands alone
            out_kind_reg  <= KIND_NONE;
            out_proc_reg  <= '0;
            out_mod_reg   <= '0;
            out_waits_reg <= waits_reg;
        end
        if (cmd.grant_show)
        begin
            out_kind_reg <= KIND_GRANT;
            out_proc_reg <= gr_rdata[PROC_W-1:0];
            out_mod_reg  <= gr_rdata[PROC_W+MOD_W-1:PROC_W];
        end
    end

    assign sts.more      = (rd_idx_reg != count_reg);
    assign sts.any_grant = (gcnt_reg != '0);
    assign sts.out_last  = out_last_reg;

    assign out_kind       = out_kind_reg;
    assign out_proc       = out_proc_reg;
    assign out_mod        = out_mod_reg;
    assign out_waits      = out_waits_reg;
    assign out_wait_total = wait_tot_reg;
    assign out_req_total  = req_tot_reg;
    assign out_last       = out_last_reg;

endmodule

### src/oldest_first_memory_bank_arbiter.sv
// Oldest-first memory bank arbiter. A request word (tuser 0) is answered
// with one accept or reject word that is valid in the cycle after it is taken.
// A tick word (tuser 1) walks the age queue; each queued request takes a
// queue RAM read, a pending-module RAM read and a decision step. A final
// queue check and a closing step end the walk; then it emits one grant word
// per grant, each from a grant RAM read and a show step, or one no-grant
// word. No input is taken until the last output word is accepted.
// One word is worked on at a time; configuration writes are always taken.
module oldest_first_memory_bank_arbiter
    import oofa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [MREG_W-1:0] cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // processor[5:0], module_req[13:6]
    input  logic              s_tuser,   // func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // processor_res, module_res, cycle_waits,
                                         // total_waits, total_requests
    output logic [KIND_W-1:0] m_tuser,   // kind
    output logic              m_tlast
);

    cmd_t cmd;
    sts_t sts;

    logic [PROC_W-1:0] out_proc;
    logic [MOD_W-1:0]  out_mod;
    logic [CNT_W-1:0]  out_waits;
    logic [TOT_W-1:0]  out_wait_total;
    logic [TOT_W-1:0]  out_req_total;

    assign cfg_ready = 1'b1;

    oofa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    oofa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_proc        (s_tdata[PROC_W-1:0]),
        .in_mod         (s_tdata[PROC_W+MOD_W-1:PROC_W]),
        .cmd            (cmd),
        .sts            (sts),
        .out_kind       (m_tuser),
        .out_proc       (out_proc),
        .out_mod        (out_mod),
        .out_waits      (out_waits),
        .out_wait_total (out_wait_total),
        .out_req_total  (out_req_total),
        .out_last       (m_tlast)
    );

    assign m_tdata = {3'b000, out_req_total, out_wait_total, out_waits, out_mod, out_proc};

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    a_req_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_REQUEST) |=> (m_tvalid && m_tlast))
        else $error("request not answered by a single final word");

    a_tick_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == FUNC_TICK) |=> (!m_tvalid && !s_tready))
        else $error("tick did not start the queue walk");

endmodule
